// ===== src/lmsc_pkg.sv =====
// Shared types and constants for the mask slot cache tag store.
package lmsc_pkg;

    localparam int TILE_W = 8;
    localparam int SLOT_W = 3;

    typedef enum logic
    {
        FUNC_LOOKUP = 1'b0,
        FUNC_INVAL  = 1'b1
    } func_t;

    typedef struct packed
    {
        logic              hit;
        logic [SLOT_W-1:0] slot;
        logic              refill;
    } lmsc_res_t;

endpackage

// ===== src/lmsc_if.sv =====
// Valid/ready channel interfaces for lookup requests and results.
interface lmsc_in_if import lmsc_pkg::*; ();
    logic              valid;
    logic              ready;
    func_t             func;
    logic [TILE_W-1:0] tile_id;

    modport source (output valid, output func, output tile_id, input ready);
    modport sink   (input valid, input func, input tile_id, output ready);
endinterface

interface lmsc_out_if import lmsc_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              hit;
    logic [SLOT_W-1:0] slot;
    logic              refill;

    modport source (output valid, output hit, output slot, output refill, input ready);
    modport sink   (input valid, input hit, input slot, input refill, output ready);
endinterface

// ===== src/lmsc_lookup.sv =====
// Parallel tag match, LRU victim pick and rank update for one request.
module lmsc_lookup import lmsc_pkg::*;
#(
    parameter int SLOTS  = 8,
    parameter int TAG_W  = 8,
    parameter int IDX_W  = 3
)
(
    input  func_t                 func,
    input  logic [TAG_W-1:0]      tag,
    input  logic [SLOTS-1:0]      valid,
    input  logic [TAG_W-1:0]      tags  [SLOTS],
    input  logic [IDX_W-1:0]      ranks [SLOTS],
    output lmsc_res_t             res,
    output logic [IDX_W-1:0]      chosen,
    output logic                  alloc,
    output logic [IDX_W-1:0]      ranks_next [SLOTS]
);

    localparam logic [IDX_W-1:0] LRU_RANK = IDX_W'(SLOTS - 1);

    logic             found;
    logic [IDX_W-1:0] hit_idx;
    logic [IDX_W-1:0] lru_idx;
    logic [IDX_W-1:0] old_rank;

    always_comb
    begin
        found   = 1'b0;
        hit_idx = '0;
        lru_idx = '0;
        for (int i = 0; i < SLOTS; i++)
        begin
            // highest matching index wins
            if (valid[i] && tags[i] == tag)
            begin
                found   = 1'b1;
                hit_idx = IDX_W'(i);
            end
            if (ranks[i] == LRU_RANK)
            begin
                lru_idx = IDX_W'(i);
            end
        end
    end

    assign chosen   = found ? hit_idx : lru_idx;
    assign alloc    = (func == FUNC_LOOKUP) && !found;
    assign old_rank = ranks[chosen];

    always_comb
    begin
        for (int i = 0; i < SLOTS; i++)
        begin
            if (func == FUNC_INVAL)
            begin
                ranks_next[i] = ranks[i];
            end
            else if (IDX_W'(i) == chosen)
            begin
                ranks_next[i] = '0;
            end
            else if (ranks[i] < old_rank)
            begin
                ranks_next[i] = ranks[i] + IDX_W'(1);
            end
            else
            begin
                ranks_next[i] = ranks[i];
            end
        end
    end

    always_comb
    begin
        if (func == FUNC_INVAL)
        begin
            res = '0;
        end
        else
        begin
            res.hit    = found;
            res.slot   = SLOT_W'(chosen);
            res.refill = !found;
        end
    end

endmodule

// ===== src/lru_mask_slot_cache_core.sv =====
// Top level of the LRU mask slot cache tag store.
// Usage:
//   req carries one beat per operation: func selects lookup or invalidate,
//   tile_id names the tile for a lookup. rsp returns one beat per request
//   beat, in order: hit, slot and refill (all zero for an invalidate).
//   A lookup hit returns the matching slot; a miss takes the least recently
//   used slot, retags it and sets refill. The chosen slot becomes most
//   recently used. Invalidate clears all valid bits and keeps the recency order.
// Timing:
//   A beat taken is held in the input register, matched against all slots
//   combinationally and written to the result register, which drives rsp.
//   One beat per cycle is sustained while rsp is ready; the single tag
//   compare and rank update stage sets that rate.
// Reset: all slots invalid, slot i holds rank i (slot SLOTS-1 is least
//   recent), both channel stages empty.
// Stall: while rsp is held off, one more beat is taken into the input
//   register, then req.ready drops until the result register drains.
module lru_mask_slot_cache_core import lmsc_pkg::*;
#(
    parameter int SLOTS    = 8,
    parameter int TAG_BITS = 8
)
(
    input  logic             clk,
    input  logic             rst_n,
    lmsc_in_if.sink          req,
    lmsc_out_if.source       rsp
);

    localparam int TAG_W = (TAG_BITS < TILE_W) ? TAG_BITS : TILE_W;
    localparam int IDX_W = $clog2(SLOTS);

    logic              in_valid_reg;
    func_t             func_reg;
    logic [TILE_W-1:0] tile_reg;

    logic              out_valid_reg;
    lmsc_res_t         res_reg;

    logic [SLOTS-1:0]  slot_valid_reg;
    logic [SLOTS-1:0]  slot_valid_next;
    logic [TAG_W-1:0]  slot_tag_reg  [SLOTS];
    logic [IDX_W-1:0]  slot_rank_reg [SLOTS];
    logic [IDX_W-1:0]  slot_rank_next [SLOTS];

    logic              advance;
    logic              in_take;
    logic [TAG_W-1:0]  tag;
    lmsc_res_t         res_next;
    logic [IDX_W-1:0]  chosen;
    logic              alloc;

    assign advance   = in_valid_reg && (!out_valid_reg || rsp.ready);
    assign req.ready = !in_valid_reg || advance;
    assign in_take   = req.valid && req.ready;
    assign tag       = TAG_W'(tile_reg);

    lmsc_lookup
    #(
        .SLOTS (SLOTS),
        .TAG_W (TAG_W),
        .IDX_W (IDX_W)
    )
    u_lookup
    (
        .func       (func_reg),
        .tag        (tag),
        .valid      (slot_valid_reg),
        .tags       (slot_tag_reg),
        .ranks      (slot_rank_reg),
        .res        (res_next),
        .chosen     (chosen),
        .alloc      (alloc),
        .ranks_next (slot_rank_next)
    );

    always_comb
    begin
        slot_valid_next = slot_valid_reg;
        if (func_reg == FUNC_INVAL)
        begin
            slot_valid_next = '0;
        end
        else if (alloc)
        begin
            slot_valid_next[chosen] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            slot_valid_reg <= '0;
            for (int i = 0; i < SLOTS; i++)
            begin
                slot_rank_reg[i] <= IDX_W'(i);
            end
        end
        else
        begin
            if (in_take)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                out_valid_reg  <= 1'b1;
                slot_valid_reg <= slot_valid_next;
                slot_rank_reg  <= slot_rank_next;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            func_reg <= req.func;
            tile_reg <= req.tile_id;
        end
        if (advance)
        begin
            res_reg <= res_next;
            if (alloc)
            begin
                slot_tag_reg[chosen] <= tag;
            end
        end
    end

    assign rsp.valid  = out_valid_reg;
    assign rsp.hit    = res_reg.hit;
    assign rsp.slot   = res_reg.slot;
    assign rsp.refill = res_reg.refill;

endmodule

// ===== tb/lmsc_tb_pkg.sv =====
`timescale 1ns / 1ps
// Scoreboard class with the LRU slot predictor for the mask slot cache testbench.
package lmsc_tb_pkg;
    import lmsc_pkg::*;

    localparam int NSLOTS = 8;

    class slot_cache_scoreboard;
        logic [TILE_W-1:0] slot_tag [NSLOTS];
        logic              slot_vld [NSLOTS];
        int unsigned       slot_rank [NSLOTS];
        lmsc_res_t         expected_rsp [$];
        int                errors;

        function new();
            for (int i = 0; i < NSLOTS; i++)
            begin
                slot_tag[i]  = '0;
                slot_vld[i]  = 1'b0;
                slot_rank[i] = i;
            end
            errors = 0;
        endfunction

        function void report(string msg);
            errors++;
            if (errors <= 50)
            begin
                $display("MISMATCH @%0t: %s", $time, msg);
            end
        endfunction

        function lmsc_res_t predict_slot(func_t f, logic [TILE_W-1:0] tile);
            lmsc_res_t   r;
            int          win;
            int unsigned old;
            r = '0;
            if (f == FUNC_INVAL)
            begin
                for (int i = 0; i < NSLOTS; i++)
                begin
                    slot_vld[i] = 1'b0;
                end
                return r;
            end
            win = -1;
            for (int i = 0; i < NSLOTS; i++)
            begin
                if (slot_vld[i] && slot_tag[i] == tile)
                begin
                    win = i;
                end
            end
            if (win < 0)
            begin
                win = 0;
                for (int i = 0; i < NSLOTS; i++)
                begin
                    if (slot_rank[i] == NSLOTS - 1)
                    begin
                        win = i;
                    end
                end
                slot_tag[win] = tile;
                slot_vld[win] = 1'b1;
                r.refill = 1'b1;
            end
            else
            begin
                r.hit = 1'b1;
            end
            // promote chosen slot to most recent
            old = slot_rank[win];
            for (int i = 0; i < NSLOTS; i++)
            begin
                if (slot_rank[i] < old)
                begin
                    slot_rank[i] = slot_rank[i] + 1;
                end
            end
            slot_rank[win] = 0;
            r.slot = win[SLOT_W-1:0];
            return r;
        endfunction

        function void note_beat(func_t f, logic [TILE_W-1:0] tile);
            lmsc_res_t want;
            want = predict_slot(f, tile);
            expected_rsp.insert(expected_rsp.size(), want);
        endfunction

        function void check_beat(lmsc_res_t got);
            lmsc_res_t want;
            if (expected_rsp.size() == 0)
            begin
                report($sformatf("unexpected rsp beat hit=%0b slot=%0d refill=%0b",
                                 got.hit, got.slot, got.refill));
                return;
            end
            want = expected_rsp.pop_front();
            if (got.hit !== want.hit)
            begin
                report($sformatf("hit got %0b want %0b", got.hit, want.hit));
            end
            if (got.slot !== want.slot)
            begin
                report($sformatf("slot got %0d want %0d", got.slot, want.slot));
            end
            if (got.refill !== want.refill)
            begin
                report($sformatf("refill got %0b want %0b", got.refill, want.refill));
            end
        endfunction

        function int pending();
            return expected_rsp.size();
        endfunction
    endclass

endpackage

// ===== tb/lru_mask_slot_cache_core_tb.sv =====
`timescale 1ns / 1ps
// Top-level testbench for lru_mask_slot_cache_core: directed and random lookups.
module lru_mask_slot_cache_core_tb;
    import lmsc_pkg::*;
    import lmsc_tb_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    lmsc_in_if  req_if ();
    lmsc_out_if rsp_if ();

    lru_mask_slot_cache_core DUT
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    slot_cache_scoreboard sb = new();

    int          idle_pct  = 0;
    int          stall_pct = 0;
    int          hold_len  = 0;
    int          held      = 0;
    int          cycles    = 0;
    logic [TILE_W-1:0] work_set [12];
    int          ws_size   = 12;

    always #1 clk = ~clk;

    initial
    begin
        rsp_if.ready = 1'b0;
    end

    // receiver: random stalls, with a long hold once hold_len is set
    always @(posedge clk)
    begin
        if (hold_len != 0 && held < hold_len)
        begin
            held <= held + 1;
            rsp_if.ready <= 1'b0;
        end
        else
        begin
            rsp_if.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && req_if.valid && req_if.ready)
        begin
            sb.note_beat(req_if.func, req_if.tile_id);
        end
    end

    always @(posedge clk)
    begin : mon_rsp
        lmsc_res_t got;
        if (rst_n && rsp_if.valid && rsp_if.ready)
        begin
            got.hit    = rsp_if.hit;
            got.slot   = rsp_if.slot;
            got.refill = rsp_if.refill;
            sb.check_beat(got);
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic send_beat(func_t f, logic [TILE_W-1:0] tile);
        while ($urandom_range(99) < idle_pct)
        begin
            req_if.valid <= 1'b0;
            @(posedge clk);
        end
        req_if.valid   <= 1'b1;
        req_if.func    <= f;
        req_if.tile_id <= tile;
        @(posedge clk);
        while (!req_if.ready)
        begin
            @(posedge clk);
        end
    endtask

    task automatic drain();
        req_if.valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() > 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic send_random(int n);
        int r;
        for (int k = 0; k < n; k++)
        begin
            if ($urandom_range(99) < 2)
            begin
                work_set[$urandom_range(11)] = TILE_W'($urandom_range(255));
            end
            r = $urandom_range(99);
            if (r < 3)
            begin
                send_beat(FUNC_INVAL, TILE_W'($urandom_range(255)));
            end
            else if (r < 88)
            begin
                send_beat(FUNC_LOOKUP, work_set[$urandom_range(ws_size - 1)]);
            end
            else
            begin
                send_beat(FUNC_LOOKUP, TILE_W'($urandom_range(255)));
            end
        end
    endtask

    initial
    begin
        req_if.valid   = 1'b0;
        req_if.func    = FUNC_LOOKUP;
        req_if.tile_id = '0;
        for (int i = 0; i < 12; i++)
        begin
            work_set[i] = TILE_W'($urandom_range(255));
        end
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: invalidate on reset state, extremes, MRU hit, eviction
        send_beat(FUNC_INVAL, 8'hFF);
        send_beat(FUNC_LOOKUP, 8'h00);
        send_beat(FUNC_LOOKUP, 8'h00);
        send_beat(FUNC_LOOKUP, 8'hFF);
        for (int t = 1; t <= 6; t++)
        begin
            send_beat(FUNC_LOOKUP, t[TILE_W-1:0]);
        end
        send_beat(FUNC_LOOKUP, 8'h80);
        send_beat(FUNC_LOOKUP, 8'h00);
        send_beat(FUNC_LOOKUP, 8'hFF);
        send_beat(FUNC_LOOKUP, 8'h03);
        send_beat(FUNC_INVAL, 8'h00);
        send_beat(FUNC_LOOKUP, 8'hFF);
        send_beat(FUNC_LOOKUP, 8'h55);
        send_beat(FUNC_LOOKUP, 8'hAA);
        send_beat(FUNC_LOOKUP, 8'h55);
        send_beat(FUNC_INVAL, 8'h55);
        send_beat(FUNC_LOOKUP, 8'hAA);
        drain();

        // long receiver hold while the sender keeps offering beats
        hold_len = 300;
        send_random(40);
        drain();

        idle_pct = 0;  stall_pct = 0;  ws_size = 12;
        send_random(375);
        drain();
        idle_pct = 68; stall_pct = 0;  ws_size = 6;
        send_random(375);
        drain();
        idle_pct = 0;  stall_pct = 68; ws_size = 12;
        send_random(375);
        drain();
        idle_pct = 28; stall_pct = 28; ws_size = 10;
        send_random(375);
        drain();

        repeat (8) @(posedge clk);
        if (sb.pending() > 0)
        begin
            sb.report($sformatf("%0d expected rsp beats never arrived", sb.pending()));
        end
        if (sb.errors == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
